[rtl/afct_pkg.sv]
package afct_pkg;

    // request kinds carried on s_tuser
    typedef enum logic [1:0] {
        ACT_LOAD_VIEW = 2'd0,
        ACT_LOAD_PROJ = 2'd1,
        ACT_TEST      = 2'd2,
        ACT_NONE      = 2'd3
    } action_t;

    // clip matrix rebuild sequencer
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_WAIT,
        SEQ_RUN,
        SEQ_FLUSH
    } seq_state_t;

    localparam int ELEM_W  = 32;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int CLIP_W  = PROD_W + 2;
    localparam int PLANE_W = CLIP_W + 1;
    localparam int LO_W    = 34;
    localparam int HI_W    = PLANE_W - LO_W;

endpackage

[rtl/aabb_frustum_cull_test.sv]
// axis-aligned box against view frustum culling test
//
// s_ channel: s_tuser is the request kind (load view element, load
// projection element, test box, or unused). s_tdata carries the element
// index and value for loads and the box corners for tests.
// m_ channel: one result per test request, m_tdata[0] = 1 when the box is
// at least partly inside the frustum. loads and unused kinds give nothing.
//
// tests run through a five register pipeline (box capture, partial
// products, product assembly, plane distance sign, output register), one
// box per cycle while no rebuild runs and the receiver keeps up. each stage moves
// when the next is empty or moving, so a stalled receiver only backs up
// the pipeline and s_tready drops once every stage is full.
// a load writes the matrix element at once, then the block waits for the
// tests in flight to leave the distance stage and rebuilds clip = proj*view
// with one shared 32x32 multiplier, 64 products in turn; through the wait,
// the rebuild and the flush that follows, s_tready is low.
// reset (aresetn low, synchronous) clears both matrices, the clip matrix
// and all valid bits, so a test straight after reset reports inside.
module aabb_frustum_cull_test
    import afct_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // element_index[3:0], element_value[35:4], min_x[67:36], min_y[99:68],
    // min_z[131:100], max_x[163:132], max_y[195:164], max_z[227:196]
    input  logic [231:0] s_tdata,
    // action[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // inside_res[0]
    output logic [7:0]   m_tdata
);

    // room for the corner products plus the shifted constant term, and the sum of four
    localparam int TERM_W = (PLANE_W + FRAC_BITS > PLANE_W + ELEM_W) ?
                            PLANE_W + FRAC_BITS : PLANE_W + ELEM_W;
    localparam int DIST_W = TERM_W + 2;

    // request fields
    action_t                   s_action;
    logic [3:0]                s_index;
    logic signed [ELEM_W-1:0]  s_value;
    logic signed [ELEM_W-1:0]  s_min [3];
    logic signed [ELEM_W-1:0]  s_max [3];

    assign s_action = action_t'(s_tuser);
    assign s_index  = s_tdata[3:0];
    assign s_value  = $signed(s_tdata[35:4]);
    assign s_min[0] = $signed(s_tdata[67:36]);
    assign s_min[1] = $signed(s_tdata[99:68]);
    assign s_min[2] = $signed(s_tdata[131:100]);
    assign s_max[0] = $signed(s_tdata[163:132]);
    assign s_max[1] = $signed(s_tdata[195:164]);
    assign s_max[2] = $signed(s_tdata[227:196]);

    // matrix storage, column-major, index column*4+row
    logic signed [ELEM_W-1:0]  view_reg [16];
    logic signed [ELEM_W-1:0]  proj_reg [16];
    // clip matrix, index row*4+column
    logic signed [CLIP_W-1:0]  clip_reg [16];
    // plane p = row3 + row(p/2) for even p, row3 - row(p/2) for odd p
    logic signed [PLANE_W-1:0] plane_reg  [6][4];
    logic signed [PLANE_W-1:0] plane_next [6][4];

    // sequencer
    seq_state_t               seq_reg, seq_next;
    logic [5:0]               cnt_reg;
    logic                     mul_v_reg;
    logic [5:0]               mul_tag_reg;
    logic signed [PROD_W-1:0] mul_reg;
    logic signed [CLIP_W-1:0] acc_reg;
    logic signed [CLIP_W-1:0] acc_next;
    logic [1:0]               seq_row, seq_col, seq_k;

    // pipeline
    logic                      v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic                      en1, en2, en3, en4, en_out;
    logic                      s_acc, pipe_empty;
    logic signed [ELEM_W-1:0]  min1_reg [3];
    logic signed [ELEM_W-1:0]  max1_reg [3];
    logic signed [LO_W+ELEM_W:0]    plo2_reg [6][3];
    logic signed [HI_W+ELEM_W-1:0]  phi2_reg [6][3];
    logic signed [DIST_W-1:0]  prod3_reg [6][3];
    logic [5:0]                neg4_reg;
    logic                      inside_reg;

    assign en_out     = !vo_reg || m_tready;
    assign en4        = !v4_reg || en_out;
    assign en3        = !v3_reg || en4;
    assign en2        = !v2_reg || en3;
    assign en1        = !v1_reg || en2;
    assign s_tready   = en1 && (seq_reg == SEQ_IDLE);
    assign s_acc      = s_tvalid && s_tready;
    assign pipe_empty = !v1_reg && !v2_reg && !v3_reg && !v4_reg;

    assign m_tvalid = vo_reg;
    assign m_tdata  = {7'd0, inside_reg};

    // matrix loads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                view_reg[i] <= '0;
                proj_reg[i] <= '0;
            end
        end else if (s_acc) begin
            if (s_action == ACT_LOAD_VIEW) begin
                view_reg[s_index] <= s_value;
            end
            if (s_action == ACT_LOAD_PROJ) begin
                proj_reg[s_index] <= s_value;
            end
        end
    end

    // sequencer: cnt = {row, col, k}, one product proj[k][row] * view[col][k] a cycle
    assign seq_row = cnt_reg[5:4];
    assign seq_col = cnt_reg[3:2];
    assign seq_k   = cnt_reg[1:0];

    always_comb begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SEQ_IDLE: begin
                if (s_acc && (s_action == ACT_LOAD_VIEW || s_action == ACT_LOAD_PROJ)) begin
                    seq_next = SEQ_WAIT;
                end
            end
            SEQ_WAIT: begin
                if (pipe_empty) begin
                    seq_next = SEQ_RUN;
                end
            end
            SEQ_RUN: begin
                if (cnt_reg == 6'd63) begin
                    seq_next = SEQ_FLUSH;
                end
            end
            SEQ_FLUSH: begin
                seq_next = SEQ_IDLE;
            end
            default: seq_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= SEQ_IDLE;
            cnt_reg   <= '0;
            mul_v_reg <= 1'b0;
        end else begin
            seq_reg   <= seq_next;
            mul_v_reg <= (seq_reg == SEQ_RUN);
            if (seq_reg == SEQ_RUN) begin
                cnt_reg <= cnt_reg + 6'd1;
            end else begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mul_tag_reg <= cnt_reg;
        mul_reg     <= proj_reg[{seq_k, seq_row}] * view_reg[{seq_col, seq_k}];
    end

    assign acc_next = ((mul_tag_reg[1:0] == 2'd0) ? CLIP_W'(0) : acc_reg) + CLIP_W'(mul_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                clip_reg[i] <= '0;
            end
        end else if (mul_v_reg) begin
            acc_reg <= acc_next;
            if (mul_tag_reg[1:0] == 2'd3) begin
                clip_reg[mul_tag_reg[5:2]] <= acc_next;
            end
        end
    end

    // plane coefficients from the clip matrix rows
    always_comb begin
        for (int p = 0; p < 6; p++) begin
            for (int k = 0; k < 4; k++) begin
                if (p % 2 == 1) begin
                    plane_next[p][k] = PLANE_W'(clip_reg[12 + k]) -
                                       PLANE_W'(clip_reg[(p / 2) * 4 + k]);
                end else begin
                    plane_next[p][k] = PLANE_W'(clip_reg[12 + k]) +
                                       PLANE_W'(clip_reg[(p / 2) * 4 + k]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        plane_reg <= plane_next;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (en1)    v1_reg <= s_acc && (s_action == ACT_TEST);
            if (en2)    v2_reg <= v1_reg;
            if (en3)    v3_reg <= v2_reg;
            if (en4)    v4_reg <= v3_reg;
            if (en_out) vo_reg <= v4_reg;
        end
    end

    // box capture
    always_ff @(posedge aclk) begin
        if (en1) begin
            min1_reg <= s_min;
            max1_reg <= s_max;
        end
    end

    // partial products: far corner times plane normal, split low/high
    always_ff @(posedge aclk) begin
        if (en2) begin
            for (int p = 0; p < 6; p++) begin
                for (int a = 0; a < 3; a++) begin
                    plo2_reg[p][a] <= $signed({1'b0, plane_reg[p][a][LO_W-1:0]}) *
                                      (plane_reg[p][a][PLANE_W-1] ? min1_reg[a] : max1_reg[a]);
                    phi2_reg[p][a] <= $signed(plane_reg[p][a][PLANE_W-1:LO_W]) *
                                      (plane_reg[p][a][PLANE_W-1] ? min1_reg[a] : max1_reg[a]);
                end
            end
        end
    end

    // product assembly
    always_ff @(posedge aclk) begin
        if (en3) begin
            for (int p = 0; p < 6; p++) begin
                for (int a = 0; a < 3; a++) begin
                    prod3_reg[p][a] <= (DIST_W'(phi2_reg[p][a]) <<< LO_W) +
                                       DIST_W'(plo2_reg[p][a]);
                end
            end
        end
    end

    // distance sign per plane
    always_ff @(posedge aclk) begin
        if (en4) begin
            for (int p = 0; p < 6; p++) begin
                neg4_reg[p] <= ((DIST_W'(plane_reg[p][3]) <<< FRAC_BITS) +
                                prod3_reg[p][0] + prod3_reg[p][1] +
                                prod3_reg[p][2]) < 0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            inside_reg <= ~|neg4_reg;
        end
    end

    // no test request taken while the clip matrix is stale
    a_no_test_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> seq_reg == SEQ_IDLE)
        else $error("request accepted during clip rebuild");

    // rebuild only with the distance pipeline empty
    a_run_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == SEQ_RUN |-> pipe_empty)
        else $error("clip rebuild with tests in flight");

    // a result held at the last stage is not lost on a stall
    a_hold_v4: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && !en_out |=> v4_reg && vo_reg)
        else $error("stalled result dropped");

endmodule

[test/tb_aabb_frustum_cull_test.sv]
module tb_aabb_frustum_cull_test;
    import afct_pkg::*;

    localparam int FRAC    = 16;
    localparam int WD_MAX  = 20000;  // cycles with no handshake before giving up
    localparam int TAIL    = 200;    // settle time after the last result

    typedef struct packed {
        logic [31:0] max_z;
        logic [31:0] max_y;
        logic [31:0] max_x;
        logic [31:0] min_z;
        logic [31:0] min_y;
        logic [31:0] min_x;
        logic [31:0] value;
        logic [3:0]  index;
    } box_data_t;

    typedef struct {
        action_t   act;
        box_data_t d;
    } cull_req_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [231:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;

    aabb_frustum_cull_test #(.FRAC_BITS(FRAC)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor copy of the two matrices, column-major
    logic signed [31:0] view_mat [16];
    logic signed [31:0] proj_mat [16];

    cull_req_t pending_reqs[$];
    bit        inside_expected[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        failed;
    bit        stim_done;
    int        quiet_cycles;
    bit        in_taken;        // request accepted at the last rising edge

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // exact inside test: planes row3 +/- row r of proj*view, wide sums
    function automatic bit frustum_inside(box_data_t b);
        logic signed [33:0]  a [4];
        logic signed [127:0] plane [4];
        logic signed [127:0] dist_sum;
        logic signed [127:0] corner [3];
        logic signed [31:0]  mn [3];
        logic signed [31:0]  mx [3];
        mn[0] = b.min_x; mn[1] = b.min_y; mn[2] = b.min_z;
        mx[0] = b.max_x; mx[1] = b.max_y; mx[2] = b.max_z;
        for (int r = 0; r < 3; r++) begin
            for (int sg = 0; sg < 2; sg++) begin
                for (int j = 0; j < 4; j++) begin
                    if (sg == 0)
                        a[j] = 34'(proj_mat[j*4+3]) + 34'(proj_mat[j*4+r]);
                    else
                        a[j] = 34'(proj_mat[j*4+3]) - 34'(proj_mat[j*4+r]);
                end
                for (int k = 0; k < 4; k++) begin
                    plane[k] = '0;
                    for (int j = 0; j < 4; j++)
                        plane[k] += 128'(a[j]) * 128'(view_mat[k*4+j]);
                end
                dist_sum = plane[3] <<< FRAC;
                for (int k = 0; k < 3; k++) begin
                    corner[k] = plane[k][127] ? 128'(mn[k]) : 128'(mx[k]);
                    dist_sum += plane[k] * corner[k];
                end
                if (dist_sum[127])
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] rand_q(int mode);
        case (mode % 5)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            3: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
            default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
        endcase
    endfunction

    function automatic cull_req_t mk_req(action_t act, int mode);
        cull_req_t q;
        q.act = act;
        q.d.index = 4'($urandom_range(0, 15));
        q.d.value = rand_q(mode);
        q.d.min_x = rand_q(mode); q.d.min_y = rand_q(mode); q.d.min_z = rand_q(mode);
        q.d.max_x = rand_q(mode); q.d.max_y = rand_q(mode); q.d.max_z = rand_q(mode);
        return q;
    endfunction

    function automatic cull_req_t mk_load(action_t act, int idx, logic [31:0] v);
        cull_req_t q;
        q = mk_req(act, 0);
        q.d.index = 4'(idx);
        q.d.value = v;
        return q;
    endfunction

    // driver: a request leaves the queue once it has been accepted
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (in_taken)
                void'(pending_reqs.pop_front());
            if (s_tvalid && !in_taken)
                s_tvalid <= 1'b1;
            else if (pending_reqs.size() > 0
                     && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_reqs[0].act;
                s_tdata  <= 232'(pending_reqs[0].d);
            end else begin
                s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: predict at input accept, compare at output accept
    always @(posedge aclk) begin
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                case (action_t'(s_tuser))
                    ACT_LOAD_VIEW: view_mat[s_tdata[3:0]] = s_tdata[35:4];
                    ACT_LOAD_PROJ: proj_mat[s_tdata[3:0]] = s_tdata[35:4];
                    ACT_TEST:      inside_expected.push_back(
                                       frustum_inside(box_data_t'(s_tdata[227:0])));
                    default: ;
                endcase
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (inside_expected.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, m_tdata[0]);
                    failed = 1'b1;
                end else if (m_tdata[0] !== inside_expected[0]) begin
                    $display("%0t: inside_res mismatch, expected %0d, actual %0d",
                             $time, inside_expected[0], m_tdata[0]);
                    failed = 1'b1;
                    void'(inside_expected.pop_front());
                end else begin
                    void'(inside_expected.pop_front());
                end
            end
            if (quiet_cycles >= WD_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        cull_req_t q;
        int n;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = ACT_NONE; m_tready = 1'b0;
        aresetn = 1'b0; failed = 1'b0; stim_done = 1'b0; quiet_cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        foreach (view_mat[i]) begin
            view_mat[i] = '0;
            proj_mat[i] = '0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: all-zero matrices report inside, then identity matrices
        pending_reqs.push_back(mk_req(ACT_TEST, 2));
        pending_reqs.push_back(mk_req(ACT_NONE, 0));
        for (int i = 0; i < 4; i++) begin
            pending_reqs.push_back(mk_load(ACT_LOAD_VIEW, i*5, 32'h0001_0000));
            pending_reqs.push_back(mk_load(ACT_LOAD_PROJ, i*5, 32'h0001_0000));
        end
        // box inside the unit cube, box far outside, swapped corners
        q = mk_req(ACT_TEST, 3);
        q.d.min_x = 32'hffff_8000; q.d.max_x = 32'h0000_8000;
        pending_reqs.push_back(q);
        q = mk_req(ACT_TEST, 0);
        q.d.min_x = 32'h0005_0000; q.d.max_x = 32'h0006_0000;
        pending_reqs.push_back(q);
        q.d.min_x = 32'h0006_0000; q.d.max_x = 32'h0005_0000;
        pending_reqs.push_back(q);
        // extremes: largest magnitudes in two matrix elements and in every box coordinate
        pending_reqs.push_back(mk_load(ACT_LOAD_PROJ, 3, 32'h8000_0000));
        pending_reqs.push_back(mk_load(ACT_LOAD_VIEW, 12, 32'h7fff_ffff));
        pending_reqs.push_back(mk_req(ACT_TEST, 2));
        pending_reqs.push_back(mk_req(ACT_TEST, 2));

        // random phases: no idling, sender idle, receiver stalls, both
        for (int ph = 0; ph < 4; ph++) begin
            wait (pending_reqs.size() == 0 && inside_expected.size() == 0);
            send_idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 14 : 0;
            recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 14 : 0;
            n = 0;
            while (n < 250) begin
                // now and then one to four loads, then a burst of tests
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 4))
                        pending_reqs.push_back(mk_req(action_t'($urandom_range(0, 1)),
                                                      $urandom_range(0, 4)));
                end
                if ($urandom_range(0, 19) == 0)
                    pending_reqs.push_back(mk_req(ACT_NONE, 0));
                repeat ($urandom_range(3, 12)) begin
                    pending_reqs.push_back(mk_req(ACT_TEST, $urandom_range(0, 4)));
                    n++;
                end
            end
        end
        stim_done = 1'b1;
        wait (pending_reqs.size() == 0 && inside_expected.size() == 0);
        repeat (TAIL) @(posedge aclk);
        if (!failed && inside_expected.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
